@@ hw/rtl/slms_pkg.sv @@
// package for the lane-mask stack unit: widths, depths, op and fault codes
// no dependencies
package slms_pkg;
   localparam int LANES        = 32;
   localparam int MASK_DEPTH   = 32;
   localparam int LOOP_DEPTH   = 8;
   localparam int FRAME_DEPTH  = 8;
   localparam int ADDRESS_BITS = 12;
   localparam int MCW = $clog2(MASK_DEPTH + 1);
   localparam int MIW = $clog2(MASK_DEPTH);
   localparam int LCW = $clog2(LOOP_DEPTH + 1);
   localparam int LIW = (LOOP_DEPTH > 1) ? $clog2(LOOP_DEPTH) : 1;
   localparam int FCW = $clog2(FRAME_DEPTH + 1);
   localparam int FIW = (FRAME_DEPTH > 1) ? $clog2(FRAME_DEPTH) : 1;

   typedef enum logic [3:0] {
      OP_START = 4'd0, OP_MASK = 4'd1, OP_MASK_NOT = 4'd2, OP_POP_MASK = 4'd3,
      OP_LOOP = 4'd4, OP_LOOP_TEST = 4'd5, OP_LOOP_RESTORE = 4'd6, OP_LOOP_END = 4'd7,
      OP_POP_LOOP = 4'd8, OP_BREAK = 4'd9, OP_CONTINUE = 4'd10, OP_ENTER = 4'd11,
      OP_LEAVE = 4'd12, OP_RETURN = 4'd13, OP_JUMP = 4'd14, OP_JUMP_IF_ZERO = 4'd15
   } op_type;

   typedef enum logic [1:0] {
      FAULT_NONE = 2'd0, FAULT_NO_LOOP = 2'd1, FAULT_OVER = 2'd2, FAULT_UNDER = 2'd3
   } fault_type;

   typedef struct packed {
      logic [3:0]  op;
      logic [31:0] cond_bits;
      logic [11:0] target;
   } req_type;

   typedef struct packed {
      logic [31:0] active_mask;
      logic        any_live;
      logic        redirect;
      logic [11:0] redirect_address;
      logic [1:0]  fault;
   } rsp_type;

   // controller to datapath
   typedef struct packed {
      logic capture;  // latch the item and read stack tops
      logic execute;  // apply the op, build the result
   } cmd_type;
endpackage

@@ hw/rtl/slms_if.sv @@
// valid/ready channel carrying one item of a payload type
// depends on slms_pkg
interface slms_req_if;
   import slms_pkg::*;
   logic    valid;
   logic    ready;
   req_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

interface slms_rsp_if;
   import slms_pkg::*;
   logic    valid;
   logic    ready;
   rsp_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

interface slms_csr_if;
   logic       valid;
   logic       ready;
   logic [5:0] data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

@@ hw/rtl/slms_ctrl.sv @@
// controller: accept, execute, hold result until taken
// depends on slms_pkg
module slms_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output slms_pkg::cmd_type cmd
);
   import slms_pkg::*;

   typedef enum logic [1:0] {ST_IDLE, ST_EXEC, ST_HOLD} state_type;
   state_type state_ff;

   always_comb begin
      req_ready   = (state_ff == ST_IDLE);
      rsp_valid   = (state_ff == ST_HOLD);
      cmd.capture = req_ready && req_valid;
      cmd.execute = (state_ff == ST_EXEC);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         unique case (state_ff)
            ST_IDLE: if (req_valid) state_ff <= ST_EXEC;
            ST_EXEC: state_ff <= ST_HOLD;
            ST_HOLD: if (rsp_ready) state_ff <= ST_IDLE;
            default: state_ff <= ST_IDLE;
         endcase
      end
   end
endmodule

@@ hw/rtl/slms_dp.sv @@
// datapath: mask, loop and frame stacks and result register
// depends on slms_pkg
module slms_dp (
   input  logic              clock,
   input  logic              reset,
   input  slms_pkg::cmd_type cmd,
   input  slms_pkg::req_type req,
   input  logic              csr_we,
   input  logic [5:0]        csr_data,
   output slms_pkg::rsp_type rsp
);
   import slms_pkg::*;

   logic [LANES-1:0]        mask_ff [MASK_DEPTH];
   logic [MCW-1:0]          mcount_ff;
   logic [LANES-1:0]        llanes_ff [LOOP_DEPTH];
   logic [MCW-1:0]          lbase_ff [LOOP_DEPTH];
   logic [ADDRESS_BITS-1:0] lexit_ff [LOOP_DEPTH];
   logic [LCW-1:0]          lcount_ff;
   logic [MCW-1:0]          fmbase_ff [FRAME_DEPTH];
   logic [LCW-1:0]          flbase_ff [FRAME_DEPTH];
   logic [FCW-1:0]          fcount_ff;
   logic [5:0]              liu_ff;
   req_type                 item_ff;
   logic [LANES-1:0]        top_ff, llt_ff;
   logic [MCW-1:0]          lbt_ff, fmb_ff;
   logic [LCW-1:0]          flb_ff;
   logic [ADDRESS_BITS-1:0] lext_ff;
   rsp_type                 rsp_ff;

   logic [LANES-1:0] lm;
   logic [6:0]       nl;
   logic [MIW-1:0]   mtop;
   logic [LIW-1:0]   ltop;
   logic [FIW-1:0]   ftop;

   always_comb begin
      nl = {1'b0, liu_ff};
      if (nl == 7'd0) nl = 7'd1;
      if (nl > 7'(LANES)) nl = 7'(LANES);
      for (int i = 0; i < LANES; i++) lm[i] = (7'(i) < nl);
      mtop = MIW'(mcount_ff - MCW'(1));
      ltop = LIW'(lcount_ff - LCW'(1));
      ftop = FIW'(fcount_ff - FCW'(1));
   end

   // execute-cycle combinational results
   logic [LANES-1:0]        live, cb, newtop;
   logic                    redir;
   logic [ADDRESS_BITS-1:0] raddr;
   fault_type               flt;
   op_type                  op;
   logic                    m_full, l_full, f_full, no_loop;
   logic [ADDRESS_BITS-1:0] tgt;

   always_comb begin
      op      = op_type'(item_ff.op);
      cb      = LANES'(item_ff.cond_bits);
      tgt     = ADDRESS_BITS'(item_ff.target);
      live    = top_ff & lm;
      m_full  = (mcount_ff >= MCW'(MASK_DEPTH));
      l_full  = (lcount_ff >= LCW'(LOOP_DEPTH));
      f_full  = (fcount_ff >= FCW'(FRAME_DEPTH));
      no_loop = (lcount_ff == '0);
      redir   = 1'b0;
      raddr   = '0;
      flt     = FAULT_NONE;
      newtop  = live;
      unique case (op)
         OP_START: newtop = lm;
         OP_MASK, OP_MASK_NOT: begin
            if (m_full) flt = FAULT_OVER;
            else begin
               newtop = live & ((op == OP_MASK) ? cb : ~cb) & lm;
               if (newtop == '0) begin
                  redir = 1'b1;
                  raddr = tgt;
               end
            end
         end
         OP_POP_MASK: if (mcount_ff <= MCW'(1)) flt = FAULT_UNDER;
         OP_LOOP: if (m_full || l_full) flt = FAULT_OVER;
         OP_LOOP_TEST, OP_LOOP_RESTORE, OP_LOOP_END: begin
            if (no_loop) flt = FAULT_UNDER;
            else begin
               newtop = (op == OP_LOOP_TEST) ? (llt_ff & cb) : llt_ff;
               if (op == OP_LOOP_END) begin
                  redir = 1'b1;
                  raddr = ((newtop & lm) != '0) ? tgt : lext_ff;
               end else if ((newtop & lm) == '0) begin
                  redir = 1'b1;
                  raddr = lext_ff;
               end
            end
         end
         OP_POP_LOOP: if (no_loop || mcount_ff <= MCW'(1)) flt = FAULT_UNDER;
         OP_BREAK, OP_CONTINUE: begin
            if (no_loop) flt = FAULT_NO_LOOP;
            else if (lbt_ff <= MCW'(mtop)) newtop = top_ff & ~live;
            else newtop = top_ff;
         end
         OP_ENTER: if (m_full || f_full) flt = FAULT_OVER;
         OP_LEAVE: if (fcount_ff == '0) flt = FAULT_UNDER;
         OP_RETURN: newtop = top_ff & ~live;
         OP_JUMP: begin
            redir = 1'b1;
            raddr = tgt;
         end
         OP_JUMP_IF_ZERO: if (!item_ff.cond_bits[0]) begin
            redir = 1'b1;
            raddr = tgt;
         end
         default: ;
      endcase
   end

   // new stack counts after the op (start, push, pop, leave): the new top is read in the result stage below
   logic [MCW-1:0] mcount_in;
   logic [LCW-1:0] lcount_in;
   logic [MCW-1:0] ret_mb;
   logic [LCW-1:0] ret_lb;

   always_comb begin
      mcount_in = mcount_ff;
      lcount_in = lcount_ff;
      ret_mb    = (fcount_ff != '0) ? fmb_ff : '0;
      ret_lb    = (fcount_ff != '0) ? flb_ff : '0;
      if (flt == FAULT_NONE) begin
         unique case (op)
            OP_START:    begin mcount_in = MCW'(1); lcount_in = '0; end
            OP_MASK, OP_MASK_NOT, OP_ENTER: mcount_in = mcount_ff + MCW'(1);
            OP_LOOP: begin
               mcount_in = mcount_ff + MCW'(1);
               lcount_in = lcount_ff + LCW'(1);
            end
            OP_POP_MASK: mcount_in = mcount_ff - MCW'(1);
            OP_POP_LOOP: begin
               mcount_in = mcount_ff - MCW'(1);
               lcount_in = lcount_ff - LCW'(1);
            end
            OP_LEAVE: begin
               if (fmb_ff < mcount_ff && fmb_ff >= MCW'(1)) mcount_in = fmb_ff;
               if (flb_ff < lcount_ff) lcount_in = flb_ff;
            end
            default: ;
         endcase
      end
   end

   // once pend_ff is set by execute: read the new top of the mask stack, whatever the op
   logic             fix_ff;
   logic [MIW-1:0]   rd_idx;

   always_ff @(posedge clock) begin
      if (reset) begin
         mcount_ff <= MCW'(1);
         lcount_ff <= '0;
         fcount_ff <= '0;
         liu_ff    <= 6'd32;
         mask_ff[0] <= '1;
      end else begin
         if (csr_we) liu_ff <= csr_data;
         if (cmd.capture) begin
            item_ff <= req;
            top_ff  <= mask_ff[mtop];
            llt_ff  <= llanes_ff[ltop];
            lbt_ff  <= lbase_ff[ltop];
            lext_ff <= lexit_ff[ltop];
            fmb_ff  <= fmbase_ff[ftop];
            flb_ff  <= flbase_ff[ftop];
         end
         if (cmd.execute) begin
            mcount_ff <= mcount_in;
            lcount_ff <= lcount_in;
            if (flt == FAULT_NONE) begin
               unique case (op)
                  OP_START: begin
                     mask_ff[0] <= lm;
                     fcount_ff  <= '0;
                  end
                  OP_MASK, OP_MASK_NOT: mask_ff[MIW'(mcount_ff)] <= newtop;
                  OP_LOOP: begin
                     mask_ff[MIW'(mcount_ff)] <= live;
                     llanes_ff[LIW'(lcount_ff)] <= live;
                     lbase_ff[LIW'(lcount_ff)]  <= mcount_ff;
                     lexit_ff[LIW'(lcount_ff)]  <= tgt;
                  end
                  OP_ENTER: begin
                     mask_ff[MIW'(mcount_ff)]   <= top_ff;
                     fmbase_ff[FIW'(fcount_ff)] <= mcount_ff;
                     flbase_ff[FIW'(fcount_ff)] <= lcount_ff;
                     fcount_ff <= fcount_ff + FCW'(1);
                  end
                  OP_LOOP_TEST, OP_LOOP_RESTORE, OP_LOOP_END: begin
                     mask_ff[mtop] <= newtop;
                     if (op == OP_LOOP_TEST) llanes_ff[ltop] <= newtop;
                  end
                  OP_BREAK, OP_CONTINUE: begin
                     for (int i = 0; i < MASK_DEPTH; i++)
                        if (MCW'(i) >= lbt_ff && MCW'(i) < mcount_ff)
                           mask_ff[i] <= mask_ff[i] & ~live;
                     if (op == OP_BREAK) llanes_ff[ltop] <= llt_ff & ~live;
                  end
                  OP_LEAVE: fcount_ff <= fcount_ff - FCW'(1);
                  OP_RETURN: begin
                     for (int i = 0; i < MASK_DEPTH; i++)
                        if (MCW'(i) >= ret_mb && MCW'(i) < mcount_ff)
                           mask_ff[i] <= mask_ff[i] & ~live;
                     for (int i = 0; i < LOOP_DEPTH; i++)
                        if (LCW'(i) >= ret_lb && LCW'(i) < lcount_ff)
                           llanes_ff[i] <= llanes_ff[i] & ~live;
                  end
                  default: ;
               endcase
            end
         end
      end
   end

   always_comb rd_idx = MIW'(mcount_ff - MCW'(1));

   // result register: exec writes flags, the following cycle takes the top
   logic             pend_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff <= 1'b0;
      end else begin
         pend_ff <= cmd.execute;
         if (cmd.execute) begin
            rsp_ff.redirect         <= redir;
            rsp_ff.redirect_address <= raddr;
            rsp_ff.fault            <= flt;
         end
         if (pend_ff) begin
            rsp_ff.active_mask <= 32'(mask_ff[rd_idx] & lm);
            rsp_ff.any_live    <= (mask_ff[rd_idx] & lm) != '0;
         end
      end
   end

   always_comb fix_ff = pend_ff;
   always_comb begin
      rsp = rsp_ff;
      if (fix_ff) begin
         rsp.active_mask = 32'(mask_ff[rd_idx] & lm);
         rsp.any_live    = (mask_ff[rd_idx] & lm) != '0;
      end
   end
endmodule

@@ hw/rtl/simt_lane_mask_stack_unit.sv @@
// top level of the lane-mask stack unit: controller plus datapath
// depends on slms_pkg, slms_if, slms_ctrl, slms_dp
//
//  channel  dir  fields
//  req_     in   op, cond_bits, target
//  rsp_     out  active_mask, any_live, redirect, redirect_address, fault
//  csr_     in   lanes_in_use (always ready)
//
// the accept edge captures the item and reads the stack tops, the next cycle executes
// the result is offered from the hold state that follows execute and holds until taken
// the next item is accepted the cycle after the result is taken, never before it
// so a stalled result side also holds off the next item
// synchronous reset restores one all-lanes mask and empty loop and frame stacks
module simt_lane_mask_stack_unit (
   input logic     clock,
   input logic     reset,
   slms_req_if.sink   req,
   slms_rsp_if.source rsp,
   slms_csr_if.sink   csr
);
   import slms_pkg::*;

   cmd_type cmd;

   assign csr.ready = 1'b1;

   // sequencing of capture, execute and hold
   slms_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req.valid),
      .req_ready (req.ready),
      .rsp_valid (rsp.valid),
      .rsp_ready (rsp.ready),
      .cmd       (cmd)
   );

   // stacks and result
   slms_dp u_dp (
      .clock    (clock),
      .reset    (reset),
      .cmd      (cmd),
      .req      (req.data),
      .csr_we   (csr.valid),
      .csr_data (csr.data),
      .rsp      (rsp.data)
   );
endmodule

@@ sim/slms_result_checker.sv @@
`timescale 1ns / 100ps
// checker for the lane-mask stack unit: watches the three channels, predicts each result
// depends on slms_pkg and slms_if
module slms_result_checker (
   input  logic clock,
   input  logic reset,
   slms_req_if  req,
   slms_rsp_if  rsp,
   slms_csr_if  csr,
   output int   fail_count,
   output int   pending
);
   import slms_pkg::*;

   logic [5:0]  lanes_reg;
   logic [31:0] masks [MASK_DEPTH];
   int          mask_cnt;
   logic [31:0] loop_lanes [LOOP_DEPTH];
   int          loop_base [LOOP_DEPTH];
   logic [11:0] loop_exit [LOOP_DEPTH];
   int          loop_cnt;
   int          frame_mbase [FRAME_DEPTH];
   int          frame_lbase [FRAME_DEPTH];
   int          frame_cnt;
   rsp_type     expected_rsps [$];

   function automatic logic [31:0] lanes_mask();
      int n;
      n = lanes_reg;
      if (n == 0) n = 1;
      if (n > LANES) n = LANES;
      lanes_mask = (n >= 32) ? 32'hffff_ffff : ((32'd1 << n) - 32'd1);
   endfunction

   function automatic logic [31:0] top_lanes();
      top_lanes = masks[(mask_cnt - 1) % MASK_DEPTH] & lanes_mask();
   endfunction

   function automatic void empty_stacks();
      mask_cnt = 1;
      masks[0] = lanes_mask();
      loop_cnt = 0;
      frame_cnt = 0;
   endfunction

   function automatic void strip_masks(input int base, input logic [31:0] going);
      for (int i = base; i < mask_cnt && i < MASK_DEPTH; i++) masks[i] &= ~going;
   endfunction

   function automatic rsp_type step_stacks(input req_type r);
      rsp_type     o;
      logic [31:0] lm, c, going;
      logic [1:0]  flt;
      logic        redir;
      logic [11:0] addr;
      int          lt, mb, lb;
      lm = lanes_mask();
      flt = FAULT_NONE;
      redir = 1'b0;
      addr = '0;
      lt = (loop_cnt + LOOP_DEPTH - 1) % LOOP_DEPTH;
      case (op_type'(r.op))
         OP_START: empty_stacks();
         OP_MASK, OP_MASK_NOT: begin
            if (mask_cnt >= MASK_DEPTH) flt = FAULT_OVER;
            else begin
               c = (r.op == OP_MASK) ? r.cond_bits : ~r.cond_bits;
               masks[mask_cnt] = top_lanes() & c & lm;
               mask_cnt++;
               if (top_lanes() == 0) begin
                  redir = 1'b1;
                  addr = r.target;
               end
            end
         end
         OP_POP_MASK: begin
            if (mask_cnt <= 1) flt = FAULT_UNDER;
            else mask_cnt--;
         end
         OP_LOOP: begin
            if (mask_cnt >= MASK_DEPTH || loop_cnt >= LOOP_DEPTH) flt = FAULT_OVER;
            else begin
               loop_lanes[loop_cnt] = top_lanes();
               loop_base[loop_cnt] = mask_cnt;
               loop_exit[loop_cnt] = r.target;
               masks[mask_cnt] = loop_lanes[loop_cnt];
               loop_cnt++;
               mask_cnt++;
            end
         end
         OP_LOOP_TEST, OP_LOOP_RESTORE, OP_LOOP_END: begin
            if (loop_cnt == 0) flt = FAULT_UNDER;
            else begin
               if (r.op == OP_LOOP_TEST) loop_lanes[lt] &= r.cond_bits;
               masks[mask_cnt - 1] = loop_lanes[lt];
               if (r.op == OP_LOOP_END) begin
                  redir = 1'b1;
                  addr = (top_lanes() != 0) ? r.target : loop_exit[lt];
               end else if (top_lanes() == 0) begin
                  redir = 1'b1;
                  addr = loop_exit[lt];
               end
            end
         end
         OP_POP_LOOP: begin
            if (loop_cnt == 0 || mask_cnt <= 1) flt = FAULT_UNDER;
            else begin
               mask_cnt--;
               loop_cnt--;
            end
         end
         OP_BREAK, OP_CONTINUE: begin
            if (loop_cnt == 0) flt = FAULT_NO_LOOP;
            else begin
               going = top_lanes();
               strip_masks(loop_base[lt], going);
               if (r.op == OP_BREAK) loop_lanes[lt] &= ~going;
            end
         end
         OP_ENTER: begin
            if (mask_cnt >= MASK_DEPTH || frame_cnt >= FRAME_DEPTH) flt = FAULT_OVER;
            else begin
               frame_mbase[frame_cnt] = mask_cnt;
               frame_lbase[frame_cnt] = loop_cnt;
               frame_cnt++;
               masks[mask_cnt] = masks[mask_cnt - 1];
               mask_cnt++;
            end
         end
         OP_LEAVE: begin
            if (frame_cnt == 0) flt = FAULT_UNDER;
            else begin
               frame_cnt--;
               if (frame_mbase[frame_cnt] < mask_cnt && frame_mbase[frame_cnt] >= 1)
                  mask_cnt = frame_mbase[frame_cnt];
               if (frame_lbase[frame_cnt] < loop_cnt) loop_cnt = frame_lbase[frame_cnt];
            end
         end
         OP_RETURN: begin
            going = top_lanes();
            mb = frame_cnt ? frame_mbase[frame_cnt - 1] : 0;
            lb = frame_cnt ? frame_lbase[frame_cnt - 1] : 0;
            strip_masks(mb, going);
            for (int i = lb; i < loop_cnt && i < LOOP_DEPTH; i++) loop_lanes[i] &= ~going;
         end
         OP_JUMP: begin
            redir = 1'b1;
            addr = r.target;
         end
         default: begin
            if (!r.cond_bits[0]) begin
               redir = 1'b1;
               addr = r.target;
            end
         end
      endcase
      o.active_mask = top_lanes();
      o.any_live = (o.active_mask != 0);
      o.redirect = redir;
      o.redirect_address = redir ? addr : '0;
      o.fault = flt;
      step_stacks = o;
   endfunction

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         lanes_reg = 6'd32;
         empty_stacks();
         expected_rsps.delete();
         fail_count <= 0;
      end else begin
         if (rsp.valid && rsp.ready) begin
            if (expected_rsps.size() == 0) begin
               $display("%0t: result with no item pending, actual %p", $time, rsp.data);
               fail_count <= fail_count + 1;
            end else begin
               want = expected_rsps.pop_front();
               if (want.active_mask !== rsp.data.active_mask ||
                   want.any_live !== rsp.data.any_live ||
                   want.redirect !== rsp.data.redirect ||
                   want.redirect_address !== rsp.data.redirect_address ||
                   want.fault !== rsp.data.fault) begin
                  $display("%0t: mismatch, expected %p actual %p", $time, want, rsp.data);
                  fail_count <= fail_count + 1;
               end
            end
         end
         if (csr.valid && csr.ready) lanes_reg = csr.data;
         if (req.valid && req.ready)
            expected_rsps.insert(expected_rsps.size(), step_stacks(req.data));
      end
      pending <= expected_rsps.size();
   end
endmodule

@@ sim/simt_lane_mask_stack_unit_test.sv @@
`timescale 1ns / 100ps
// stimulus and verdict for the lane-mask stack unit
// depends on slms_pkg, slms_if, slms_result_checker and the unit itself
module simt_lane_mask_stack_unit_test;
   import slms_pkg::*;

   localparam int STALL_LIMIT = 3000;   // cycles with no handshake at all

   logic clock;
   logic reset;
   int   fail_count;
   int   pending;
   bit   no_idle;      // phases with back-to-back traffic on both sides
   int   quiet_cycles;

   slms_req_if req ();
   slms_rsp_if rsp ();
   slms_csr_if csr ();

   simt_lane_mask_stack_unit u_top (
      .clock (clock),
      .reset (reset),
      .req   (req),
      .rsp   (rsp),
      .csr   (csr)
   );

   slms_result_checker u_check (
      .clock      (clock),
      .reset      (reset),
      .req        (req),
      .rsp        (rsp),
      .csr        (csr),
      .fail_count (fail_count),
      .pending    (pending)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // watchdog: any handshake on any channel counts as progress
   always @(posedge clock) begin
      if (reset || (req.valid && req.ready) || (rsp.valid && rsp.ready) ||
          (csr.valid && csr.ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= STALL_LIMIT) begin
            $display("simt_lane_mask_stack_unit regression: fail");
            $finish;
         end
      end
   end

   // result side: random stall before taking each item
   initial begin
      int gap;
      rsp.ready <= 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         gap = no_idle ? 0 : $urandom_range(0, 12);
         if (gap > 0) begin
            rsp.ready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp.ready <= 1'b1;
         // valid is settled by the falling edge, so the next rising edge takes the item
         do @(negedge clock); while (!rsp.valid);
         @(posedge clock);
      end
   end

   // one item out on the request channel, after a random gap
   task automatic send_op(input op_type op, input logic [31:0] cond, input logic [11:0] tgt);
      int gap;
      gap = no_idle ? 0 : $urandom_range(0, 12);
      if (gap > 0) begin
         req.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req.valid <= 1'b1;
      req.data.op <= op;
      req.data.cond_bits <= cond;
      req.data.target <= tgt;
      do @(negedge clock); while (!req.ready);
      @(posedge clock);
   endtask

   // drain every pending result, then let the unit settle before a register write
   task automatic drain();
      req.valid <= 1'b0;
      do @(negedge clock); while (pending != 0);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_lanes(input logic [5:0] value);
      drain();
      csr.valid <= 1'b1;
      csr.data <= value;
      do @(negedge clock); while (!csr.ready);
      @(posedge clock);
      csr.valid <= 1'b0;
   endtask

   function automatic logic [31:0] pick_cond();
      case ($urandom_range(0, 7))
         0: pick_cond = 32'h0;
         1: pick_cond = 32'hffff_ffff;
         2: pick_cond = 32'd1 << $urandom_range(0, 31);
         3: pick_cond = ~(32'd1 << $urandom_range(0, 31));
         default: pick_cond = $urandom;
      endcase
   endfunction

   function automatic logic [11:0] pick_target();
      case ($urandom_range(0, 9))
         0: pick_target = 12'h000;
         1: pick_target = 12'hfff;
         default: pick_target = $urandom_range(0, 4095);
      endcase
   endfunction

   // growing phases favor pushes so the stacks fill; shrinking ones favor pops
   function automatic op_type pick_op(input bit grow);
      int r;
      r = $urandom_range(0, 99);
      if (!grow && r < 40) begin
         case ($urandom_range(0, 2))
            0: pick_op = OP_POP_MASK;
            1: pick_op = OP_POP_LOOP;
            default: pick_op = OP_LEAVE;
         endcase
      end else if (r < 14) pick_op = OP_MASK;
      else if (r < 25) pick_op = OP_MASK_NOT;
      else if (r < 35) pick_op = OP_LOOP;
      else if (r < 43) pick_op = OP_ENTER;
      else if (r < 51) pick_op = OP_LOOP_TEST;
      else if (r < 56) pick_op = OP_LOOP_RESTORE;
      else if (r < 61) pick_op = OP_LOOP_END;
      else if (r < 66) pick_op = OP_BREAK;
      else if (r < 70) pick_op = OP_CONTINUE;
      else if (r < 75) pick_op = OP_POP_MASK;
      else if (r < 79) pick_op = OP_POP_LOOP;
      else if (r < 83) pick_op = OP_LEAVE;
      else if (r < 87) pick_op = OP_RETURN;
      else if (r < 92) pick_op = OP_JUMP;
      else if (r < 98) pick_op = OP_JUMP_IF_ZERO;
      else pick_op = OP_START;
   endfunction

   initial begin
      logic [5:0] lane_settings [9];
      lane_settings = '{6'd32, 6'd1, 6'd0, 6'd63, 6'd17, 6'd5, 6'd31, 6'd2, 6'd32};
      no_idle = 1'b0;
      reset <= 1'b1;
      req.valid <= 1'b0;
      req.data <= '0;
      csr.valid <= 1'b0;
      csr.data <= '0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // directed: jumps first, then ops on empty stacks
      send_op(OP_JUMP, 32'h0, 12'hfff);
      send_op(OP_JUMP_IF_ZERO, 32'h0, 12'h000);
      send_op(OP_JUMP_IF_ZERO, 32'h1, 12'hfff);
      send_op(OP_POP_MASK, 32'h0, 12'h0);
      send_op(OP_LOOP_TEST, 32'hffff_ffff, 12'h0);
      send_op(OP_LOOP_RESTORE, 32'h0, 12'h0);
      send_op(OP_LOOP_END, 32'h0, 12'h0);
      send_op(OP_POP_LOOP, 32'h0, 12'h0);
      send_op(OP_BREAK, 32'h0, 12'h0);
      send_op(OP_CONTINUE, 32'h0, 12'h0);
      send_op(OP_LEAVE, 32'h0, 12'h0);
      send_op(OP_RETURN, 32'h0, 12'h0);
      // mask that kills every lane, then its inverse
      send_op(OP_MASK, 32'h0, 12'hfff);
      send_op(OP_MASK_NOT, 32'h0, 12'h123);
      send_op(OP_START, 32'h0, 12'h0);
      // a loop inside a function with break, continue and a stale frame base
      send_op(OP_ENTER, 32'h0, 12'h0);
      send_op(OP_LOOP, 32'h0, 12'h0aa);
      send_op(OP_LOOP_TEST, 32'h0f0f_0f0f, 12'h0);
      send_op(OP_MASK, 32'h0000_ffff, 12'h050);
      send_op(OP_BREAK, 32'h0, 12'h0);
      send_op(OP_CONTINUE, 32'h0, 12'h0);
      send_op(OP_LOOP_END, 32'h0, 12'h010);
      send_op(OP_POP_LOOP, 32'h0, 12'h0);
      send_op(OP_RETURN, 32'h0, 12'h0);
      send_op(OP_LEAVE, 32'h0, 12'h0);

      // random phases, one lane setting each; the drain before each write is the pause
      foreach (lane_settings[p]) begin
         write_lanes(lane_settings[p]);
         no_idle = (p == 3 || p == 6);
         if ($urandom_range(0, 1)) send_op(OP_START, pick_cond(), pick_target());
         for (int i = 0; i < 160; i++)
            send_op(pick_op((i % 80) < 50), pick_cond(), pick_target());
      end

      drain();
      repeat (10) @(posedge clock);
      if (fail_count == 0 && pending == 0) begin
         $display("simt_lane_mask_stack_unit regression: pass");
      end else begin
         $display("simt_lane_mask_stack_unit regression: fail");
      end
      $finish;
   end
endmodule
